// ===== rtl/dru_pkg.sv =====
// ----------------------------------------------------------------------------
// DDA ray setup package
// Shared constants, direction codes, stage enables and helper functions.
// ----------------------------------------------------------------------------
package dru_pkg;

   localparam int POS_W    = 20;
   localparam int DIR_W    = 16;
   localparam int COEFF_W  = 32;
   localparam int DIST_W   = 32;
   localparam int STEP_W   = 10;
   localparam int TILE_W   = 9;
   localparam int MAP_W    = 13;
   localparam int FAR_W    = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [TILE_W-1:0] TILE_MAX = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_EDGE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd2;

   localparam logic [1:0] DIR_ZERO = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd2;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_en_type;

   function automatic logic [TILE_W-1:0] tile_clamp(input logic [TILE_W-1:0] raw);
      logic [TILE_W-1:0] res;
      if (raw == '0) begin
         res = 9'd1;
      end else if (raw > TILE_MAX) begin
         res = TILE_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

   function automatic logic [MAP_W-1:0] map_extent(input logic [MAP_W-1:0] w,
                                                   input logic [MAP_W-1:0] h);
      return (w > h) ? w : h;
   endfunction

endpackage

// ===== rtl/dda_ray_setup_unit.sv =====
// ----------------------------------------------------------------------------
// DDA ray setup unit
// Per-ray setup of a grid DDA traversal: side distances, tile steps, delta
// distances, first axis and far limit.
// ----------------------------------------------------------------------------
//  port group | direction | flow control
//  req_*      | in        | req_valid / req_stall, one ray per word
//  rsp_*      | out       | rsp_valid / rsp_stall, one setup per word
//  csr_*      | in        | csr_write, index and data, no wait
//
// One ray enters per cycle while req_stall is low.
// The seven register stages are three tile remainder slices, gap, the gap
// times coefficient multiplier, saturation and the compare.
// Reset clears the stage valid bits and loads the register defaults.
// A stage holds only while the stage after it is full and held, so bubbles
// close up and new words enter while a result waits on rsp_stall.
// ----------------------------------------------------------------------------
module dda_ray_setup_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dru_pkg::POS_W-1:0]          req_start_x,
   input  logic [dru_pkg::POS_W-1:0]          req_start_y,
   input  logic signed [dru_pkg::DIR_W-1:0]   req_dir_cos,
   input  logic signed [dru_pkg::DIR_W-1:0]   req_dir_sin,
   input  logic signed [dru_pkg::COEFF_W-1:0] req_coeff_x,
   input  logic signed [dru_pkg::COEFF_W-1:0] req_coeff_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dru_pkg::DIST_W-1:0]         rsp_side_dist_x,
   output logic [dru_pkg::DIST_W-1:0]         rsp_side_dist_y,
   output logic signed [dru_pkg::STEP_W-1:0]  rsp_step_x,
   output logic signed [dru_pkg::STEP_W-1:0]  rsp_step_y,
   output logic [dru_pkg::DIST_W-1:0]         rsp_delta_dist_x,
   output logic [dru_pkg::DIST_W-1:0]         rsp_delta_dist_y,
   output logic                               rsp_first_axis,
   output logic [dru_pkg::FAR_W-1:0]          rsp_far_limit,
   input  logic                               csr_write,
   input  logic [dru_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dru_pkg::MAP_W-1:0]          csr_data
);
   import dru_pkg::*;

   logic [TILE_W-1:0] tile_edge_ff;
   logic [MAP_W-1:0]  map_width_ff;
   logic [MAP_W-1:0]  map_height_ff;

   logic [7:1]        valid_ff;
   logic [7:1]        valid_in;
   logic [7:1]        adv;
   stage_en_type      en;

   logic [TILE_W-1:0] tile;
   logic [MAP_W-1:0]  extent;

   logic [DIST_W-1:0] side_x;
   logic [DIST_W-1:0] side_y;
   logic signed [STEP_W-1:0] step_x;
   logic signed [STEP_W-1:0] step_y;
   logic [DIST_W-1:0] delta_x;
   logic [DIST_W-1:0] delta_y;

   logic [DIST_W-1:0] side_x_ff;
   logic [DIST_W-1:0] side_y_ff;
   logic signed [STEP_W-1:0] step_x_ff;
   logic signed [STEP_W-1:0] step_y_ff;
   logic [DIST_W-1:0] delta_x_ff;
   logic [DIST_W-1:0] delta_y_ff;
   logic              first_axis_ff;
   logic [FAR_W-1:0]  far_limit_ff;

   assign tile   = tile_clamp(tile_edge_ff);
   assign extent = map_extent(map_width_ff, map_height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_edge_ff  <= 9'd64;
         map_width_ff  <= 13'd256;
         map_height_ff <= 13'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TILE_EDGE:  tile_edge_ff  <= csr_data[TILE_W-1:0];
            CSR_MAP_WIDTH:  map_width_ff  <= csr_data;
            CSR_MAP_HEIGHT: map_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      adv[7] = !valid_ff[7] || !rsp_stall;
      for (int k = 6; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = adv[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= 7; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      en.s1 = adv[1];
      en.s2 = adv[2];
      en.s3 = adv[3];
      en.s4 = adv[4];
      en.s5 = adv[5];
      en.s6 = adv[6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   dru_axis u_axis_x (
      .clock       (clock),
      .en          (en),
      .pos_is_next (1'b1),
      .tile        (tile),
      .extent      (extent),
      .in_start    (req_start_x),
      .in_dir      (req_dir_cos),
      .in_coeff    (req_coeff_x),
      .side_dist   (side_x),
      .step        (step_x),
      .delta_dist  (delta_x)
   );

   dru_axis u_axis_y (
      .clock       (clock),
      .en          (en),
      .pos_is_next (1'b0),
      .tile        (tile),
      .extent      (extent),
      .in_start    (req_start_y),
      .in_dir      (req_dir_sin),
      .in_coeff    (req_coeff_y),
      .side_dist   (side_y),
      .step        (step_y),
      .delta_dist  (delta_y)
   );

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         side_x_ff     <= side_x;
         side_y_ff     <= side_y;
         step_x_ff     <= step_x;
         step_y_ff     <= step_y;
         delta_x_ff    <= delta_x;
         delta_y_ff    <= delta_y;
         first_axis_ff <= (side_x < side_y) ? 1'b0 : 1'b1;
         far_limit_ff  <= {extent, 1'b0};
      end
   end

   assign req_stall        = !adv[1];
   assign rsp_valid        = valid_ff[7];
   assign rsp_side_dist_x  = side_x_ff;
   assign rsp_side_dist_y  = side_y_ff;
   assign rsp_step_x       = step_x_ff;
   assign rsp_step_y       = step_y_ff;
   assign rsp_delta_dist_x = delta_x_ff;
   assign rsp_delta_dist_y = delta_y_ff;
   assign rsp_first_axis   = first_axis_ff;
   assign rsp_far_limit    = far_limit_ff;

endmodule

// ===== rtl/dru_rem_step.sv =====
// ----------------------------------------------------------------------------
// DDA ray setup remainder slice
// Four restoring division steps; keeps only the running remainder.
// ----------------------------------------------------------------------------
module dru_rem_step (
   input  logic [dru_pkg::TILE_W-1:0] rem_i,
   input  logic [3:0]                 bits_i,
   input  logic [dru_pkg::TILE_W-1:0] divisor,
   output logic [dru_pkg::TILE_W-1:0] rem_o
);
   import dru_pkg::*;

   always_comb begin
      logic [TILE_W-1:0] r;
      logic [TILE_W:0]   r_shift;
      r = rem_i;
      for (int i = 3; i >= 0; i--) begin
         r_shift = {r, bits_i[i]};
         if (r_shift >= {1'b0, divisor}) begin
            r_shift = r_shift - {1'b0, divisor};
         end
         r = r_shift[TILE_W-1:0];
      end
      rem_o = r;
   end

endmodule

// ===== rtl/dru_axis.sv =====
// ----------------------------------------------------------------------------
// DDA ray setup axis pipeline
// Six stages for one axis: classify, tile remainder, gap, side and delta
// distance with saturation.
// ----------------------------------------------------------------------------
module dru_axis (
   input  logic                              clock,
   input  dru_pkg::stage_en_type             en,
   input  logic                              pos_is_next,
   input  logic [dru_pkg::TILE_W-1:0]        tile,
   input  logic [dru_pkg::MAP_W-1:0]         extent,
   input  logic [dru_pkg::POS_W-1:0]         in_start,
   input  logic signed [dru_pkg::DIR_W-1:0]  in_dir,
   input  logic signed [dru_pkg::COEFF_W-1:0] in_coeff,
   output logic [dru_pkg::DIST_W-1:0]        side_dist,
   output logic signed [dru_pkg::STEP_W-1:0] step,
   output logic [dru_pkg::DIST_W-1:0]        delta_dist
);
   import dru_pkg::*;

   logic [POS_W-1:0]   pos1_ff;
   logic [1:0]         dir1_ff;
   logic [COEFF_W-1:0] mag1_ff;
   logic [TILE_W-1:0]  rem1_ff;

   logic [11:0]        pos2_ff;
   logic [1:0]         dir2_ff;
   logic [COEFF_W-1:0] mag2_ff;
   logic [TILE_W-1:0]  rem2_ff;
   logic [40:0]        dprod2_ff;

   logic [7:0]         frac3_ff;
   logic [1:0]         dir3_ff;
   logic [COEFF_W-1:0] mag3_ff;
   logic [TILE_W-1:0]  rem3_ff;
   logic [DIST_W-1:0]  delta3_ff;

   logic [16:0]        gap4_ff;
   logic               zero4_ff;
   logic signed [STEP_W-1:0] step4_ff;
   logic [COEFF_W-1:0] mag4_ff;
   logic [DIST_W-1:0]  delta4_ff;

   logic [48:0]        prod5_ff;
   logic               zero5_ff;
   logic signed [STEP_W-1:0] step5_ff;
   logic [DIST_W-1:0]  delta5_ff;

   logic [DIST_W-1:0]  side6_ff;
   logic signed [STEP_W-1:0] step6_ff;
   logic [DIST_W-1:0]  delta6_ff;

   logic [1:0]         dir1_in;
   logic [COEFF_W-1:0] mag1_in;
   logic [TILE_W-1:0]  rem1_in;
   logic [TILE_W-1:0]  rem2_in;
   logic [TILE_W-1:0]  rem3_in;
   logic               next4;
   logic [16:0]        rem_full;
   logic [16:0]        gap4_in;
   logic signed [STEP_W-1:0] step4_in;
   logic [DIST_W-1:0]  side6_in;

   dru_rem_step u_rem_a (
      .rem_i   ('0),
      .bits_i  (in_start[19:16]),
      .divisor (tile),
      .rem_o   (rem1_in)
   );

   dru_rem_step u_rem_b (
      .rem_i   (rem1_ff),
      .bits_i  (pos1_ff[15:12]),
      .divisor (tile),
      .rem_o   (rem2_in)
   );

   dru_rem_step u_rem_c (
      .rem_i   (rem2_ff),
      .bits_i  (pos2_ff[11:8]),
      .divisor (tile),
      .rem_o   (rem3_in)
   );

   always_comb begin
      if (in_dir == '0) begin
         dir1_in = DIR_ZERO;
      end else if (in_dir[DIR_W-1]) begin
         dir1_in = DIR_NEG;
      end else begin
         dir1_in = DIR_POS;
      end
      mag1_in = in_coeff[COEFF_W-1] ? (~in_coeff + 32'd1) : in_coeff;
   end

   always_comb begin
      next4    = (dir3_ff == DIR_POS) ? pos_is_next : !pos_is_next;
      rem_full = {rem3_ff, frac3_ff};
      gap4_in  = next4 ? ({tile, 8'd0} - rem_full) : rem_full;
      if (dir3_ff == DIR_ZERO) begin
         step4_in = '0;
      end else if (next4) begin
         step4_in = $signed({1'b0, tile});
      end else begin
         step4_in = -$signed({1'b0, tile});
      end
   end

   always_comb begin
      if (zero5_ff) begin
         side6_in = {11'd0, extent, 8'd0};
      end else if (prod5_ff[48]) begin
         side6_in = '1;
      end else begin
         side6_in = prod5_ff[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         pos1_ff <= in_start;
         dir1_ff <= dir1_in;
         mag1_ff <= mag1_in;
         rem1_ff <= rem1_in;
      end
      if (en.s2) begin
         pos2_ff   <= pos1_ff[11:0];
         dir2_ff   <= dir1_ff;
         mag2_ff   <= mag1_ff;
         rem2_ff   <= rem2_in;
         dprod2_ff <= 41'(tile) * 41'(mag1_ff);
      end
      if (en.s3) begin
         frac3_ff  <= pos2_ff[7:0];
         dir3_ff   <= dir2_ff;
         mag3_ff   <= mag2_ff;
         rem3_ff   <= rem3_in;
         delta3_ff <= dprod2_ff[40] ? '1 : dprod2_ff[39:8];
      end
      if (en.s4) begin
         gap4_ff   <= gap4_in;
         zero4_ff  <= (dir3_ff == DIR_ZERO);
         step4_ff  <= step4_in;
         mag4_ff   <= mag3_ff;
         delta4_ff <= delta3_ff;
      end
      if (en.s5) begin
         prod5_ff  <= 49'(gap4_ff) * 49'(mag4_ff);
         zero5_ff  <= zero4_ff;
         step5_ff  <= step4_ff;
         delta5_ff <= delta4_ff;
      end
      if (en.s6) begin
         side6_ff  <= side6_in;
         step6_ff  <= step5_ff;
         delta6_ff <= delta5_ff;
      end
   end

   assign side_dist  = side6_ff;
   assign step       = step6_ff;
   assign delta_dist = delta6_ff;

endmodule

// ===== rtl/dru_checker.sv =====
// ----------------------------------------------------------------------------
// DDA ray setup checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module dru_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [dru_pkg::DIST_W-1:0]         rsp_side_dist_x,
   input logic [dru_pkg::DIST_W-1:0]         rsp_side_dist_y,
   input logic signed [dru_pkg::STEP_W-1:0]  rsp_step_x,
   input logic signed [dru_pkg::STEP_W-1:0]  rsp_step_y,
   input logic                               rsp_first_axis,
   input logic [dru_pkg::FAR_W-1:0]          rsp_far_limit
);
   import dru_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_side_dist_x)
                                 && $stable(rsp_side_dist_y))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_first_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_axis == !(rsp_side_dist_x < rsp_side_dist_y))
      else $error("first axis disagrees with side distances");

   a_zero_dir_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_x == '0 |-> rsp_side_dist_x == {11'd0, rsp_far_limit, 7'd0})
      else $error("zero x direction without map extent distance");

   a_step_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_x != '0 && rsp_step_y != '0
         |-> rsp_step_x == rsp_step_y || rsp_step_x == -rsp_step_y)
      else $error("x and y steps differ in size");

endmodule

bind dda_ray_setup_unit dru_checker u_dru_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_side_dist_x (rsp_side_dist_x),
   .rsp_side_dist_y (rsp_side_dist_y),
   .rsp_step_x      (rsp_step_x),
   .rsp_step_y      (rsp_step_y),
   .rsp_first_axis  (rsp_first_axis),
   .rsp_far_limit   (rsp_far_limit)
);
